>>> hdl/dam_pkg.sv
`timescale 1ns / 1ps

package dam_pkg;

	// field widths
	localparam int SAMPLE_W = 12;
	localparam int DAC_W    = 12;
	localparam int IDX_W    = 10;
	localparam int PHASE_W  = 32;
	localparam int GAIN_W   = 20;

	localparam int TABLE_DEPTH     = 1024;
	localparam int PHASE_FRAC_BITS = 22;

	// averaging block length, a power of two so the mean is a shift
	localparam int AVG_COUNT = 16;
	localparam int AVG_SHIFT = $clog2(AVG_COUNT);
	localparam int CNT_W     = AVG_SHIFT;
	localparam int SUM_W     = SAMPLE_W + AVG_SHIFT;

	// midscale of the 12-bit codes
	localparam int MID_CODE = 2048;
	localparam int AM_DIV   = 4095;

	// request codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	// modulation modes
	localparam logic MODE_AM = 1'b0;
	localparam logic MODE_FM = 1'b1;

	// register map
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_BASE  = 2'd1;
	localparam logic [1:0] REG_GAIN  = 2'd2;

	localparam logic [PHASE_W-1:0] BASE_STEP_RST = 32'd214748365;
	localparam logic [GAIN_W-1:0]  FM_GAIN_RST   = 20'd20972;

	typedef struct packed {
		logic                req_type;
		logic [SAMPLE_W-1:0] adc_sample;
	} in_item_t;

	typedef struct packed {
		logic [DAC_W-1:0] dac_value;
		logic [IDX_W-1:0] table_index;
	} out_item_t;

	typedef struct packed {
		logic               mode_select;
		logic [PHASE_W-1:0] base_step;
		logic [GAIN_W-1:0]  fm_gain;
	} cfg_t;

	localparam logic [DAC_W-1:0] SINE_ROM [TABLE_DEPTH] = '{
		12'd2048,12'd2060,12'd2073,12'd2085,12'd2098,12'd2110,12'd2123,12'd2135,
		12'd2148,12'd2161,12'd2173,12'd2186,12'd2198,12'd2211,12'd2223,12'd2236,
		12'd2248,12'd2261,12'd2273,12'd2286,12'd2298,12'd2311,12'd2323,12'd2335,
		12'd2348,12'd2360,12'd2373,12'd2385,12'd2398,12'd2410,12'd2422,12'd2435,
		12'd2447,12'd2459,12'd2472,12'd2484,12'd2496,12'd2508,12'd2521,12'd2533,
		12'd2545,12'd2557,12'd2569,12'd2581,12'd2594,12'd2606,12'd2618,12'd2630,
		12'd2642,12'd2654,12'd2666,12'd2678,12'd2690,12'd2702,12'd2714,12'd2725,
		12'd2737,12'd2749,12'd2761,12'd2773,12'd2784,12'd2796,12'd2808,12'd2819,
		12'd2831,12'd2843,12'd2854,12'd2866,12'd2877,12'd2889,12'd2900,12'd2912,
		12'd2923,12'd2934,12'd2946,12'd2957,12'd2968,12'd2979,12'd2990,12'd3002,
		12'd3013,12'd3024,12'd3035,12'd3046,12'd3057,12'd3068,12'd3078,12'd3089,
		12'd3100,12'd3111,12'd3122,12'd3132,12'd3143,12'd3154,12'd3164,12'd3175,
		12'd3185,12'd3195,12'd3206,12'd3216,12'd3226,12'd3237,12'd3247,12'd3257,
		12'd3267,12'd3277,12'd3287,12'd3297,12'd3307,12'd3317,12'd3327,12'd3337,
		12'd3346,12'd3356,12'd3366,12'd3375,12'd3385,12'd3394,12'd3404,12'd3413,
		12'd3423,12'd3432,12'd3441,12'd3450,12'd3459,12'd3468,12'd3477,12'd3486,
		12'd3495,12'd3504,12'd3513,12'd3522,12'd3530,12'd3539,12'd3548,12'd3556,
		12'd3565,12'd3573,12'd3581,12'd3590,12'd3598,12'd3606,12'd3614,12'd3622,
		12'd3630,12'd3638,12'd3646,12'd3654,12'd3662,12'd3669,12'd3677,12'd3685,
		12'd3692,12'd3700,12'd3707,12'd3714,12'd3722,12'd3729,12'd3736,12'd3743,
		12'd3750,12'd3757,12'd3764,12'd3771,12'd3777,12'd3784,12'd3791,12'd3797,
		12'd3804,12'd3810,12'd3816,12'd3823,12'd3829,12'd3835,12'd3841,12'd3847,
		12'd3853,12'd3859,12'd3865,12'd3871,12'd3876,12'd3882,12'd3888,12'd3893,
		12'd3898,12'd3904,12'd3909,12'd3914,12'd3919,12'd3924,12'd3929,12'd3934,
		12'd3939,12'd3944,12'd3949,12'd3953,12'd3958,12'd3962,12'd3967,12'd3971,
		12'd3975,12'd3980,12'd3984,12'd3988,12'd3992,12'd3996,12'd3999,12'd4003,
		12'd4007,12'd4010,12'd4014,12'd4017,12'd4021,12'd4024,12'd4027,12'd4031,
		12'd4034,12'd4037,12'd4040,12'd4042,12'd4045,12'd4048,12'd4051,12'd4053,
		12'd4056,12'd4058,12'd4060,12'd4063,12'd4065,12'd4067,12'd4069,12'd4071,
		12'd4073,12'd4075,12'd4076,12'd4078,12'd4080,12'd4081,12'd4083,12'd4084,
		12'd4085,12'd4086,12'd4087,12'd4088,12'd4089,12'd4090,12'd4091,12'd4092,
		12'd4093,12'd4093,12'd4094,12'd4094,12'd4094,12'd4095,12'd4095,12'd4095,
		12'd4095,12'd4095,12'd4095,12'd4095,12'd4094,12'd4094,12'd4094,12'd4093,
		12'd4093,12'd4092,12'd4091,12'd4090,12'd4089,12'd4088,12'd4087,12'd4086,
		12'd4085,12'd4084,12'd4083,12'd4081,12'd4080,12'd4078,12'd4076,12'd4075,
		12'd4073,12'd4071,12'd4069,12'd4067,12'd4065,12'd4063,12'd4060,12'd4058,
		12'd4056,12'd4053,12'd4051,12'd4048,12'd4045,12'd4042,12'd4040,12'd4037,
		12'd4034,12'd4031,12'd4027,12'd4024,12'd4021,12'd4017,12'd4014,12'd4010,
		12'd4007,12'd4003,12'd3999,12'd3996,12'd3992,12'd3988,12'd3984,12'd3980,
		12'd3975,12'd3971,12'd3967,12'd3962,12'd3958,12'd3953,12'd3949,12'd3944,
		12'd3939,12'd3934,12'd3929,12'd3924,12'd3919,12'd3914,12'd3909,12'd3904,
		12'd3898,12'd3893,12'd3888,12'd3882,12'd3876,12'd3871,12'd3865,12'd3859,
		12'd3853,12'd3847,12'd3841,12'd3835,12'd3829,12'd3823,12'd3816,12'd3810,
		12'd3804,12'd3797,12'd3791,12'd3784,12'd3777,12'd3771,12'd3764,12'd3757,
		12'd3750,12'd3743,12'd3736,12'd3729,12'd3722,12'd3714,12'd3707,12'd3700,
		12'd3692,12'd3685,12'd3677,12'd3669,12'd3662,12'd3654,12'd3646,12'd3638,
		12'd3630,12'd3622,12'd3614,12'd3606,12'd3598,12'd3590,12'd3581,12'd3573,
		12'd3565,12'd3556,12'd3548,12'd3539,12'd3530,12'd3522,12'd3513,12'd3504,
		12'd3495,12'd3486,12'd3477,12'd3468,12'd3459,12'd3450,12'd3441,12'd3432,
		12'd3423,12'd3413,12'd3404,12'd3394,12'd3385,12'd3375,12'd3366,12'd3356,
		12'd3346,12'd3337,12'd3327,12'd3317,12'd3307,12'd3297,12'd3287,12'd3277,
		12'd3267,12'd3257,12'd3247,12'd3237,12'd3226,12'd3216,12'd3206,12'd3195,
		12'd3185,12'd3175,12'd3164,12'd3154,12'd3143,12'd3132,12'd3122,12'd3111,
		12'd3100,12'd3089,12'd3078,12'd3068,12'd3057,12'd3046,12'd3035,12'd3024,
		12'd3013,12'd3002,12'd2990,12'd2979,12'd2968,12'd2957,12'd2946,12'd2934,
		12'd2923,12'd2912,12'd2900,12'd2889,12'd2877,12'd2866,12'd2854,12'd2843,
		12'd2831,12'd2819,12'd2808,12'd2796,12'd2784,12'd2773,12'd2761,12'd2749,
		12'd2737,12'd2725,12'd2714,12'd2702,12'd2690,12'd2678,12'd2666,12'd2654,
		12'd2642,12'd2630,12'd2618,12'd2606,12'd2594,12'd2581,12'd2569,12'd2557,
		12'd2545,12'd2533,12'd2521,12'd2508,12'd2496,12'd2484,12'd2472,12'd2459,
		12'd2447,12'd2435,12'd2422,12'd2410,12'd2398,12'd2385,12'd2373,12'd2360,
		12'd2348,12'd2335,12'd2323,12'd2311,12'd2298,12'd2286,12'd2273,12'd2261,
		12'd2248,12'd2236,12'd2223,12'd2211,12'd2198,12'd2186,12'd2173,12'd2161,
		12'd2148,12'd2135,12'd2123,12'd2110,12'd2098,12'd2085,12'd2073,12'd2060,
		12'd2048,12'd2035,12'd2022,12'd2010,12'd1997,12'd1985,12'd1972,12'd1960,
		12'd1947,12'd1934,12'd1922,12'd1909,12'd1897,12'd1884,12'd1872,12'd1859,
		12'd1847,12'd1834,12'd1822,12'd1809,12'd1797,12'd1784,12'd1772,12'd1760,
		12'd1747,12'd1735,12'd1722,12'd1710,12'd1697,12'd1685,12'd1673,12'd1660,
		12'd1648,12'd1636,12'd1623,12'd1611,12'd1599,12'd1587,12'd1574,12'd1562,
		12'd1550,12'd1538,12'd1526,12'd1514,12'd1501,12'd1489,12'd1477,12'd1465,
		12'd1453,12'd1441,12'd1429,12'd1417,12'd1405,12'd1393,12'd1381,12'd1370,
		12'd1358,12'd1346,12'd1334,12'd1322,12'd1311,12'd1299,12'd1287,12'd1276,
		12'd1264,12'd1252,12'd1241,12'd1229,12'd1218,12'd1206,12'd1195,12'd1183,
		12'd1172,12'd1161,12'd1149,12'd1138,12'd1127,12'd1116,12'd1105,12'd1093,
		12'd1082,12'd1071,12'd1060,12'd1049,12'd1038,12'd1027,12'd1017,12'd1006,
		12'd995,12'd984,12'd973,12'd963,12'd952,12'd941,12'd931,12'd920,
		12'd910,12'd900,12'd889,12'd879,12'd869,12'd858,12'd848,12'd838,
		12'd828,12'd818,12'd808,12'd798,12'd788,12'd778,12'd768,12'd758,
		12'd749,12'd739,12'd729,12'd720,12'd710,12'd701,12'd691,12'd682,
		12'd672,12'd663,12'd654,12'd645,12'd636,12'd627,12'd618,12'd609,
		12'd600,12'd591,12'd582,12'd573,12'd565,12'd556,12'd547,12'd539,
		12'd530,12'd522,12'd514,12'd505,12'd497,12'd489,12'd481,12'd473,
		12'd465,12'd457,12'd449,12'd441,12'd433,12'd426,12'd418,12'd410,
		12'd403,12'd395,12'd388,12'd381,12'd373,12'd366,12'd359,12'd352,
		12'd345,12'd338,12'd331,12'd324,12'd318,12'd311,12'd304,12'd298,
		12'd291,12'd285,12'd279,12'd272,12'd266,12'd260,12'd254,12'd248,
		12'd242,12'd236,12'd230,12'd224,12'd219,12'd213,12'd207,12'd202,
		12'd197,12'd191,12'd186,12'd181,12'd176,12'd171,12'd166,12'd161,
		12'd156,12'd151,12'd146,12'd142,12'd137,12'd133,12'd128,12'd124,
		12'd120,12'd115,12'd111,12'd107,12'd103,12'd99,12'd96,12'd92,
		12'd88,12'd85,12'd81,12'd78,12'd74,12'd71,12'd68,12'd64,
		12'd61,12'd58,12'd55,12'd53,12'd50,12'd47,12'd44,12'd42,
		12'd39,12'd37,12'd35,12'd32,12'd30,12'd28,12'd26,12'd24,
		12'd22,12'd20,12'd19,12'd17,12'd15,12'd14,12'd12,12'd11,
		12'd10,12'd9,12'd8,12'd7,12'd6,12'd5,12'd4,12'd3,
		12'd2,12'd2,12'd1,12'd1,12'd1,12'd0,12'd0,12'd0,
		12'd0,12'd0,12'd0,12'd0,12'd1,12'd1,12'd1,12'd2,
		12'd2,12'd3,12'd4,12'd5,12'd6,12'd7,12'd8,12'd9,
		12'd10,12'd11,12'd12,12'd14,12'd15,12'd17,12'd19,12'd20,
		12'd22,12'd24,12'd26,12'd28,12'd30,12'd32,12'd35,12'd37,
		12'd39,12'd42,12'd44,12'd47,12'd50,12'd53,12'd55,12'd58,
		12'd61,12'd64,12'd68,12'd71,12'd74,12'd78,12'd81,12'd85,
		12'd88,12'd92,12'd96,12'd99,12'd103,12'd107,12'd111,12'd115,
		12'd120,12'd124,12'd128,12'd133,12'd137,12'd142,12'd146,12'd151,
		12'd156,12'd161,12'd166,12'd171,12'd176,12'd181,12'd186,12'd191,
		12'd197,12'd202,12'd207,12'd213,12'd219,12'd224,12'd230,12'd236,
		12'd242,12'd248,12'd254,12'd260,12'd266,12'd272,12'd279,12'd285,
		12'd291,12'd298,12'd304,12'd311,12'd318,12'd324,12'd331,12'd338,
		12'd345,12'd352,12'd359,12'd366,12'd373,12'd381,12'd388,12'd395,
		12'd403,12'd410,12'd418,12'd426,12'd433,12'd441,12'd449,12'd457,
		12'd465,12'd473,12'd481,12'd489,12'd497,12'd505,12'd514,12'd522,
		12'd530,12'd539,12'd547,12'd556,12'd565,12'd573,12'd582,12'd591,
		12'd600,12'd609,12'd618,12'd627,12'd636,12'd645,12'd654,12'd663,
		12'd672,12'd682,12'd691,12'd701,12'd710,12'd720,12'd729,12'd739,
		12'd749,12'd758,12'd768,12'd778,12'd788,12'd798,12'd808,12'd818,
		12'd828,12'd838,12'd848,12'd858,12'd869,12'd879,12'd889,12'd900,
		12'd910,12'd920,12'd931,12'd941,12'd952,12'd963,12'd973,12'd984,
		12'd995,12'd1006,12'd1017,12'd1027,12'd1038,12'd1049,12'd1060,12'd1071,
		12'd1082,12'd1093,12'd1105,12'd1116,12'd1127,12'd1138,12'd1149,12'd1161,
		12'd1172,12'd1183,12'd1195,12'd1206,12'd1218,12'd1229,12'd1241,12'd1252,
		12'd1264,12'd1276,12'd1287,12'd1299,12'd1311,12'd1322,12'd1334,12'd1346,
		12'd1358,12'd1370,12'd1381,12'd1393,12'd1405,12'd1417,12'd1429,12'd1441,
		12'd1453,12'd1465,12'd1477,12'd1489,12'd1501,12'd1514,12'd1526,12'd1538,
		12'd1550,12'd1562,12'd1574,12'd1587,12'd1599,12'd1611,12'd1623,12'd1636,
		12'd1648,12'd1660,12'd1673,12'd1685,12'd1697,12'd1710,12'd1722,12'd1735,
		12'd1747,12'd1760,12'd1772,12'd1784,12'd1797,12'd1809,12'd1822,12'd1834,
		12'd1847,12'd1859,12'd1872,12'd1884,12'd1897,12'd1909,12'd1922,12'd1934,
		12'd1947,12'd1960,12'd1972,12'd1985,12'd1997,12'd2010,12'd2022,12'd2035
	};

endpackage

>>> hdl/dam_regs.sv
`timescale 1ns / 1ps

module dam_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dam_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output dam_pkg::cfg_t               cfg
);

	logic       wr_en;
	logic [1:0] reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.mode_select <= dam_pkg::MODE_AM;
			cfg.base_step   <= dam_pkg::BASE_STEP_RST;
			cfg.fm_gain     <= dam_pkg::FM_GAIN_RST;
		end else if (wr_en) begin
			case (reg_sel)
				dam_pkg::REG_MODE: cfg.mode_select <= pwdata[0];
				dam_pkg::REG_BASE: cfg.base_step   <= pwdata;
				dam_pkg::REG_GAIN: cfg.fm_gain     <= pwdata[dam_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			dam_pkg::REG_MODE: prdata = {31'd0, cfg.mode_select};
			dam_pkg::REG_BASE: prdata = cfg.base_step;
			dam_pkg::REG_GAIN: prdata = {{(32 - dam_pkg::GAIN_W){1'b0}}, cfg.fm_gain};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

>>> hdl/dam_avg.sv
`timescale 1ns / 1ps

module dam_avg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_en,
	input  logic [dam_pkg::SAMPLE_W-1:0]  adc_sample,
	output logic [dam_pkg::SAMPLE_W-1:0]  mod_level
);

	logic [dam_pkg::SUM_W-1:0] sum_q;
	logic [dam_pkg::SUM_W-1:0] sum_next;
	logic [dam_pkg::CNT_W-1:0] count_q;
	logic [dam_pkg::SAMPLE_W-1:0] level_q;
	logic                         block_done;

	assign sum_next   = sum_q + dam_pkg::SUM_W'(adc_sample);
	assign block_done = (count_q == dam_pkg::CNT_W'(dam_pkg::AVG_COUNT - 1));
	assign mod_level  = level_q;

	// floor mean of each block, then sum and count restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			level_q <= '0;
		end else if (sample_en) begin
			if (block_done) begin
				level_q <= sum_next[dam_pkg::AVG_SHIFT +: dam_pkg::SAMPLE_W];
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_next;
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

>>> hdl/dam_pipe.sv
`timescale 1ns / 1ps

module dam_pipe (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dam_pkg::cfg_t                 cfg,
	input  logic                          tick_en,
	input  logic [dam_pkg::SAMPLE_W-1:0]  mod_level,
	output logic                          tick_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output dam_pkg::out_item_t            out_data
);

	localparam int PROD_W = 26;

	// stage valids and advance enables, stage 6 is the result register
	logic [6:1] vld;
	logic [6:1] adv;

	logic [dam_pkg::SAMPLE_W-1:0] level_s1, level_s2, level_s3, level_s4;
	logic [dam_pkg::PHASE_W-1:0]  delta_s2;
	logic [dam_pkg::IDX_W-1:0]    idx_s3, idx_s4, idx_s5;
	logic [dam_pkg::DAC_W-1:0]    entry_s4, entry_s5;
	logic signed [PROD_W-1:0]     prod_s5;
	dam_pkg::out_item_t           out_s6;
	logic [dam_pkg::PHASE_W-1:0]  phase_q;

	logic signed [12:0]          lvl_off;
	logic signed [33:0]          fm_prod;
	logic [dam_pkg::PHASE_W-1:0] fm_step;
	logic [dam_pkg::PHASE_W-1:0] phase_next;
	logic signed [12:0]          entry_off;
	logic signed [PROD_W-1:0]    am_prod;
	logic signed [13:0]          am_t, am_r, am_q, am_sum;
	logic [dam_pkg::DAC_W-1:0]   am_dac;

	// a stage moves on when it is empty or the one after it moves on
	always_comb begin
		adv[6] = !vld[6] || out_ready;
		adv[5] = !vld[5] || adv[6];
		adv[4] = !vld[4] || adv[5];
		adv[3] = !vld[3] || adv[4];
		adv[2] = !vld[2] || adv[3];
		adv[1] = !vld[1] || adv[2];
	end

	assign tick_ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (adv[1]) vld[1] <= tick_en;
			if (adv[2]) vld[2] <= vld[1];
			if (adv[3]) vld[3] <= vld[2];
			if (adv[4]) vld[4] <= vld[3];
			if (adv[5]) vld[5] <= vld[4];
			if (adv[6]) vld[6] <= vld[5];
		end
	end

	// fm step offset: (level - midscale) * gain, kept modulo 2^32
	assign lvl_off = $signed({1'b0, level_s1}) - 13'sd2048;
	assign fm_prod = lvl_off * $signed({1'b0, cfg.fm_gain});

	assign fm_step    = (cfg.mode_select == dam_pkg::MODE_FM) ? delta_s2 : '0;
	assign phase_next = phase_q + cfg.base_step + fm_step;

	// am scaling product, signed entry offset times level
	assign entry_off = $signed({1'b0, entry_s4}) - 13'sd2048;
	assign am_prod   = entry_off * $signed({1'b0, level_s4});

	// floor divide by 4095: t = floor(p/4096), remainder p - 4095t lies in
	// -2048..6141, so one step up or down fixes the quotient
	always_comb begin
		am_t   = $signed(prod_s5[PROD_W-1:12]);
		am_r   = $signed({2'b00, prod_s5[11:0]}) + am_t;
		am_q   = am_t + ((am_r >= 14'sd4095) ? 14'sd1 : 14'sd0)
			- ((am_r < 14'sd0) ? 14'sd1 : 14'sd0);
		am_sum = am_q + 14'sd2048;
		am_dac = am_sum[dam_pkg::DAC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (adv[3] && vld[2]) begin
			phase_q <= phase_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1] && tick_en) begin
			level_s1 <= mod_level;
		end
		if (adv[2] && vld[1]) begin
			delta_s2 <= fm_prod[dam_pkg::PHASE_W-1:0];
			level_s2 <= level_s1;
		end
		if (adv[3] && vld[2]) begin
			idx_s3   <= phase_next[dam_pkg::PHASE_FRAC_BITS +: dam_pkg::IDX_W];
			level_s3 <= level_s2;
		end
		if (adv[4] && vld[3]) begin
			entry_s4 <= dam_pkg::SINE_ROM[idx_s3];
			idx_s4   <= idx_s3;
			level_s4 <= level_s3;
		end
		if (adv[5] && vld[4]) begin
			prod_s5  <= am_prod;
			entry_s5 <= entry_s4;
			idx_s5   <= idx_s4;
		end
		if (adv[6] && vld[5]) begin
			out_s6.dac_value   <= (cfg.mode_select == dam_pkg::MODE_FM) ? entry_s5 : am_dac;
			out_s6.table_index <= idx_s5;
		end
	end

	assign out_valid = vld[6];
	assign out_data  = out_s6;

endmodule

>>> hdl/dds_am_fm_modulator.sv
`timescale 1ns / 1ps

// channel  signals                                   payload
// in       in_valid / in_ready / in_data             in_item_t: req_type, adc_sample
// out      out_valid / out_ready / out_data          out_item_t: dac_value, table_index
// cfg      psel penable pwrite paddr pwdata prdata   mode_select, base_step, fm_gain
//
// one item per cycle is taken while in_ready is high; each tick yields one result
// phase accumulator add is the only pipeline loop, closed in a single stage
// arst_n clears phase, averaging state and stage valids, registers go to defaults
// out_ready low fills empty stages first; in_ready drops only with all 6 stages full

module dds_am_fm_modulator (
	input  logic                          clk,
	input  logic                          arst_n,

	// item input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  dam_pkg::in_item_t             in_data,

	// result output
	output logic                          out_valid,
	input  logic                          out_ready,
	output dam_pkg::out_item_t            out_data,

	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dam_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	dam_pkg::cfg_t                 cfg;
	logic                          in_xfer;
	logic                          sample_en;
	logic                          tick_en;
	logic [dam_pkg::SAMPLE_W-1:0]  mod_level;

	// samples only touch the averager, ticks enter the synthesis pipeline
	assign in_xfer   = in_valid && in_ready;
	assign sample_en = in_xfer && (in_data.req_type == dam_pkg::REQ_SAMPLE);
	assign tick_en   = in_xfer && (in_data.req_type == dam_pkg::REQ_TICK);

	dam_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// block average of adc samples into the modulation level
	dam_avg u_avg (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_en  (sample_en),
		.adc_sample (in_data.adc_sample),
		.mod_level  (mod_level)
	);

	// level snapshot, fm offset, phase step, sine lookup, am scale, result
	dam_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.tick_en    (tick_en),
		.mod_level  (mod_level),
		.tick_ready (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
